FILE: sv/rotated_tile_blit_defines.svh
// Assertion macros shared by the rotated tile blitter modules.
// Each module that uses them has clk_i and rst_ni in scope.
`ifndef ROTATED_TILE_BLIT_DEFINES_SVH
`define ROTATED_TILE_BLIT_DEFINES_SVH

// Plain property, checked every clock outside reset.
`define RTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next one.
`define RTB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/rtb_pkg.sv
// Package for the rotated tile blitter: sizes, register map, codes and the
// command word passed from the front end to the back end. No dependencies.
package rtb_pkg;

  // Tile store and panel geometry
  localparam int TILE_WIDTH   = 64;
  localparam int TILE_HEIGHT  = 64;
  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 480;
  localparam int TILE_DEPTH   = TILE_WIDTH * TILE_HEIGHT;
  localparam int TILE_AW      = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

  // Field and register widths
  localparam int PIX_W      = 16;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 7;
  localparam int OFFS_W     = 10;
  localparam int STRIDE_W   = 11;
  localparam int START_W    = 11;
  localparam int LCOL_W     = 10;
  localparam int LROW_W     = 11;
  localparam int ORG_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int DIM_MAX    = (1 << DIM_W) - 1;
  localparam int TILE_W_LIM = (TILE_WIDTH > DIM_MAX) ? DIM_MAX : TILE_WIDTH;
  localparam int TILE_H_LIM = (TILE_HEIGHT > DIM_MAX) ? DIM_MAX : TILE_HEIGHT;
  localparam int STRIDE_MAX = 1024;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION     = 3'd0,
    REG_RECT_WIDTH   = 3'd1,
    REG_RECT_HEIGHT  = 3'd2,
    REG_SRC_X_OFFSET = 3'd3,
    REG_SRC_Y_OFFSET = 3'd4,
    REG_ROW_PITCH    = 3'd5,
    REG_START_X      = 3'd6,
    REG_START_Y      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    rot_e                       rotation;
    logic [DIM_W-1:0]           rect_width;
    logic [DIM_W-1:0]           rect_height;
    logic [OFFS_W-1:0]          src_x_offset;
    logic [OFFS_W-1:0]          src_y_offset;
    logic [STRIDE_W-1:0]        row_pitch;
    logic signed [START_W-1:0]  start_x;
    logic signed [START_W-1:0]  start_y;
  } cfg_t;

  // One tile store access: a write for a load, a read plus metadata for an emit
  typedef struct packed {
    logic                       is_read;
    logic [TILE_AW-1:0]         addr;
    logic [PIX_W-1:0]           pixel;
    logic signed [COORD_W-1:0]  dest_x;
    logic signed [COORD_W-1:0]  dest_y;
    logic                       last;
  } cmd_t;

endpackage

FILE: sv/rtb_if.sv
// Valid/ready stream interfaces for the blitter's input and output words.
// Depends on rtb_pkg.
interface rtb_in_if import rtb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface rtb_out_if import rtb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PIX_W-1:0]          pixel_out;
  logic signed [COORD_W-1:0] dest_x;
  logic signed [COORD_W-1:0] dest_y;
  logic                      last;

  modport source (output valid, output pixel_out, output dest_x, output dest_y,
                  output last, input ready);
  modport sink (input valid, input pixel_out, input dest_x, input dest_y,
                input last, output ready);
endinterface

FILE: sv/rtb_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rtb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rtb_queue.sv
// Short command queue between the blitter front end and back end.
// Depends on rtb_pkg.
module rtb_queue import rtb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

FILE: sv/rtb_front.sv
// Blitter front end: takes input words, runs the load and emit counters and
// turns each word into a tile store command. Depends on rtb_pkg, rtb_if.
module rtb_front import rtb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  rtb_in_if.sink   in_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  `include "rotated_tile_blit_defines.svh"

  localparam logic [LROW_W-1:0] LROW_MAX = '1;
  localparam logic signed [ORG_W-1:0] PW = ORG_W'(PANEL_WIDTH);
  localparam logic signed [ORG_W-1:0] PH = ORG_W'(PANEL_HEIGHT);
  localparam logic signed [ORG_W-1:0] C_HI = ORG_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [ORG_W-1:0] C_LO = ~C_HI;

  logic [LCOL_W-1:0] load_col_q, load_col_d;
  logic [LROW_W-1:0] load_row_q, load_row_d;
  logic [DIM_W-1:0]  emit_c_q, emit_c_d;
  logic [DIM_W-1:0]  emit_r_q, emit_r_d;

  logic                accept, is_emit, load_acc, emit_acc, fin_acc;
  logic [DIM_W-1:0]    w, h, out_w, out_h, c, r, c_nx, src_x, src_y, rw, cw;
  logic [STRIDE_W-1:0] stride, col, col_nx;
  logic [LROW_W-1:0]   row_lim;
  logic                in_win, wrap, quarter, fin;
  logic [TILE_AW-1:0]  wr_addr, rd_addr;
  logic signed [ORG_W-1:0] sx, sy, ws, hs, ox, oy, dx, dy;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ORG_W-1:0] v
  );
    if (v > C_HI) begin
      return COORD_W'(C_HI);
    end else if (v < C_LO) begin
      return COORD_W'(C_LO);
    end else begin
      return COORD_W'(v);
    end
  endfunction

  // Clamped window and stride
  always_comb begin
    if (cfg_i.rect_width == '0) begin
      w = DIM_W'(1);
    end else if (cfg_i.rect_width > DIM_W'(TILE_W_LIM)) begin
      w = DIM_W'(TILE_W_LIM);
    end else begin
      w = cfg_i.rect_width;
    end
    if (cfg_i.rect_height == '0) begin
      h = DIM_W'(1);
    end else if (cfg_i.rect_height > DIM_W'(TILE_H_LIM)) begin
      h = DIM_W'(TILE_H_LIM);
    end else begin
      h = cfg_i.rect_height;
    end
    if (cfg_i.row_pitch == '0) begin
      stride = STRIDE_W'(1);
    end else if (cfg_i.row_pitch > STRIDE_W'(STRIDE_MAX)) begin
      stride = STRIDE_W'(STRIDE_MAX);
    end else begin
      stride = cfg_i.row_pitch;
    end
  end

  // Load path: window test and store address
  always_comb begin
    col     = (STRIDE_W'(load_col_q) >= stride) ? '0 : STRIDE_W'(load_col_q);
    row_lim = LROW_W'(cfg_i.src_y_offset) + LROW_W'(h);
    in_win  = (load_row_q >= LROW_W'(cfg_i.src_y_offset)) && (load_row_q < row_lim) &&
              (col >= STRIDE_W'(cfg_i.src_x_offset)) &&
              (col < STRIDE_W'(cfg_i.src_x_offset) + STRIDE_W'(w));
    rw      = DIM_W'(load_row_q - LROW_W'(cfg_i.src_y_offset));
    cw      = DIM_W'(col - STRIDE_W'(cfg_i.src_x_offset));
    wr_addr = TILE_AW'(rw * TILE_WIDTH) + TILE_AW'(cw);
    col_nx  = col + 1'b1;
    wrap    = (col_nx >= stride);
  end

  // Emit path: rotated walk, source address and panel coordinates
  always_comb begin
    quarter = (cfg_i.rotation == ROT_90) || (cfg_i.rotation == ROT_270);
    out_w   = quarter ? h : w;
    out_h   = quarter ? w : h;
    c       = (emit_c_q >= out_w) ? '0 : emit_c_q;
    r       = (emit_r_q >= out_h) ? '0 : emit_r_q;
    c_nx    = c + 1'b1;
    fin     = (c == out_w - 1'b1) && (r == out_h - 1'b1);
    sx      = {{(ORG_W - START_W){cfg_i.start_x[START_W-1]}}, cfg_i.start_x};
    sy      = {{(ORG_W - START_W){cfg_i.start_y[START_W-1]}}, cfg_i.start_y};
    ws      = ORG_W'(w);
    hs      = ORG_W'(h);
    case (cfg_i.rotation)
      ROT_90: begin
        src_x = r;
        src_y = h - 1'b1 - c;
        ox    = PW - (sy + hs);
        oy    = sx;
      end
      ROT_180: begin
        src_x = w - 1'b1 - c;
        src_y = h - 1'b1 - r;
        ox    = PW - (sx + ws);
        oy    = PH - (sy + hs);
      end
      ROT_270: begin
        src_x = w - 1'b1 - r;
        src_y = c;
        ox    = sy;
        oy    = PH - (sx + ws);
      end
      default: begin
        src_x = c;
        src_y = r;
        ox    = sx;
        oy    = sy;
      end
    endcase
    rd_addr = TILE_AW'(src_y * TILE_WIDTH) + TILE_AW'(src_x);
    dx      = ox + ORG_W'(c);
    dy      = oy + ORG_W'(r);
  end

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_emit    = (in_i.operation == OP_EMIT);
  assign load_acc   = accept && (in_i.operation == OP_LOAD);
  assign emit_acc   = accept && is_emit;
  assign fin_acc    = emit_acc && fin;

  assign push_o         = emit_acc || (load_acc && in_win);
  assign cmd_o.is_read  = is_emit;
  assign cmd_o.addr     = is_emit ? rd_addr : wr_addr;
  assign cmd_o.pixel    = in_i.pixel_in;
  assign cmd_o.dest_x   = sat_coord(dx);
  assign cmd_o.dest_y   = sat_coord(dy);
  assign cmd_o.last     = is_emit && fin;

  always_comb begin
    load_col_d = load_col_q;
    load_row_d = load_row_q;
    emit_c_d   = emit_c_q;
    emit_r_d   = emit_r_q;
    if (load_acc) begin
      load_col_d = wrap ? '0 : LCOL_W'(col_nx);
      if (wrap && (load_row_q != LROW_MAX)) begin
        load_row_d = load_row_q + 1'b1;
      end
    end else if (emit_acc) begin
      if (fin) begin
        emit_c_d   = '0;
        emit_r_d   = '0;
        load_col_d = '0;
        load_row_d = '0;
      end else if (c_nx >= out_w) begin
        emit_c_d = '0;
        emit_r_d = r + 1'b1;
      end else begin
        emit_c_d = c_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q <= '0;
      load_row_q <= '0;
      emit_c_q   <= '0;
      emit_r_q   <= '0;
    end else begin
      load_col_q <= load_col_d;
      load_row_q <= load_row_d;
      emit_c_q   <= emit_c_d;
      emit_r_q   <= emit_r_d;
    end
  end

  `RTB_ASSERT_NEXT(a_fin_clear, fin_acc, load_col_q == '0 && load_row_q == '0 && emit_c_q == '0 && emit_r_q == '0, "counters not cleared after last pixel")
  `RTB_ASSERT_NEXT(a_emit_step, emit_acc && !fin, emit_c_q != '0 || emit_r_q != '0, "emit walk did not advance")
  `RTB_ASSERT_NEXT(a_row_sat, load_row_q == LROW_MAX && !fin_acc, load_row_q == LROW_MAX, "load row left saturation")

endmodule

FILE: sv/rtb_back.sv
// Blitter back end: drains the command queue into the tile store, reads
// pixels for emits and holds the output word. Depends on rtb_pkg, rtb_if, rtb_ram.
module rtb_back import rtb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      pop_o,
  rtb_out_if.source out_o
);

  `include "rotated_tile_blit_defines.svh"

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic                      last;
  } rd_meta_t;

  logic             pop_wr, pop_rd, out_free, rd_free;
  logic             rd_v_q, rd_v_d;
  rd_meta_t         rd_meta_q, out_meta_q;
  logic             out_v_q, out_v_d;
  logic [PIX_W-1:0] out_pix_q, rdata;

  // Writes always drain; a read issues only when its stage will be free
  assign out_free = !out_v_q || out_o.ready;
  assign rd_free  = !rd_v_q || out_free;
  assign pop_wr   = q_valid_i && !q_cmd_i.is_read;
  assign pop_rd   = q_valid_i && q_cmd_i.is_read && rd_free;
  assign pop_o    = pop_wr || pop_rd;

  rtb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (pop_wr),
    .waddr_i (q_cmd_i.addr),
    .wdata_i (q_cmd_i.pixel),
    .re_i    (pop_rd),
    .raddr_i (q_cmd_i.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_v_d = rd_v_q;
    if (pop_rd) begin
      rd_v_d = 1'b1;
    end else if (rd_v_q && out_free) begin
      rd_v_d = 1'b0;
    end
    out_v_d = out_free ? rd_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_rd) begin
      rd_meta_q <= '{dest_x: q_cmd_i.dest_x, dest_y: q_cmd_i.dest_y, last: q_cmd_i.last};
    end
    if (rd_v_q && out_free) begin
      out_pix_q  <= rdata;
      out_meta_q <= rd_meta_q;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.dest_x    = out_meta_q.dest_x;
  assign out_o.dest_y    = out_meta_q.dest_y;
  assign out_o.last      = out_meta_q.last;

  `RTB_ASSERT_NEXT(a_rd_hold, rd_v_q && !out_free, rd_v_q && $stable(rd_meta_q), "read stage lost while output stalled")
  `RTB_ASSERT_NEXT(a_rd_issue, pop_rd, rd_v_q, "issued read has no stage")
  `RTB_ASSERT_NEXT(a_out_fill, rd_v_q && out_free, out_v_q && out_meta_q == $past(rd_meta_q), "read word not moved to output")

endmodule

FILE: sv/rotated_tile_blit.sv
// Rotated tile blitter: load source words into a tile store, then emit the
// window rotated by 0, 90, 180 or 270 degrees with panel coordinates.
// Input channel in_i: operation 0 loads one source word (raster order over
// rows of row_pitch words, only the window is kept), 1 emits the next
// rotated pixel. Output channel out_o: one word per emit, none per load.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; write only
// while no emit is outstanding.
// Throughput is one input word per clock while the queue has room, loads
// and emits alike; the tile store has one write and one read port,
// drained by the back end one command per cycle unless a read is held back.
// An emit passes through the command queue, the store read and the output
// register before it shows on out_o.
// A stalled out_o holds its word; the read stage and the four-entry command
// queue keep taking input until the queue fills, then in_i.ready drops.
// Reset clears counters, queue and valid flags, sets register defaults;
// tile store contents stay undefined until loaded, with no clearing pass.
module rotated_tile_blit import rtb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rtb_in_if.sink                in_i,
  rtb_out_if.source             out_o
);

  cfg_t cfg_q;
  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation     <= ROT_0;
      cfg_q.rect_width   <= DIM_W'(1);
      cfg_q.rect_height  <= DIM_W'(1);
      cfg_q.src_x_offset <= '0;
      cfg_q.src_y_offset <= '0;
      cfg_q.row_pitch    <= STRIDE_W'(1);
      cfg_q.start_x      <= '0;
      cfg_q.start_y      <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROTATION:     cfg_q.rotation     <= rot_e'(cfg_data_i[1:0]);
        REG_RECT_WIDTH:   cfg_q.rect_width   <= cfg_data_i[DIM_W-1:0];
        REG_RECT_HEIGHT:  cfg_q.rect_height  <= cfg_data_i[DIM_W-1:0];
        REG_SRC_X_OFFSET: cfg_q.src_x_offset <= cfg_data_i[OFFS_W-1:0];
        REG_SRC_Y_OFFSET: cfg_q.src_y_offset <= cfg_data_i[OFFS_W-1:0];
        REG_ROW_PITCH:    cfg_q.row_pitch    <= cfg_data_i[STRIDE_W-1:0];
        REG_START_X:      cfg_q.start_x      <= cfg_data_i[START_W-1:0];
        REG_START_Y:      cfg_q.start_y      <= cfg_data_i[START_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  rtb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in)
  );

  rtb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  rtb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_out),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

FILE: tb/rotated_tile_blit_checker.sv
// Scoreboard for the rotated tile blitter: follows register writes and the
// input stream, predicts each output word and compares it on arrival.
// Depends on rtb_pkg and the stream interfaces in rtb_if.sv.
module rotated_tile_blit_checker import rtb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rtb_in_if                     in_mon_i,
  rtb_out_if                    out_mon_i,
  output int                    fail_o,
  output int                    pending_o
);

  localparam int COORD_HI = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_LO = -(1 << (COORD_W - 1));
  localparam int LROW_MAX = (1 << LROW_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0]          pixel;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic                      last;
  } blit_pix_t;

  blit_pix_t pix_q[$];

  // shadow of the register file
  rot_e                      rot;
  logic [DIM_W-1:0]          rect_w, rect_h;
  logic [OFFS_W-1:0]         x_off, y_off;
  logic [STRIDE_W-1:0]       stride;
  logic signed [START_W-1:0] st_x, st_y;

  logic [PIX_W-1:0] tile_mem [TILE_DEPTH];
  int ld_col, ld_row, em_col, em_row;
  int n_bad = 0;

  assign fail_o = n_bad;

  function automatic int fit(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [COORD_W-1:0] clip_coord(int v);
    return COORD_W'(fit(v, COORD_LO, COORD_HI));
  endfunction

  task automatic apply_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ROTATION:     rot = rot_e'(d[1:0]);
      REG_RECT_WIDTH:   rect_w = d[DIM_W-1:0];
      REG_RECT_HEIGHT:  rect_h = d[DIM_W-1:0];
      REG_SRC_X_OFFSET: x_off = d[OFFS_W-1:0];
      REG_SRC_Y_OFFSET: y_off = d[OFFS_W-1:0];
      REG_ROW_PITCH:    stride = d[STRIDE_W-1:0];
      REG_START_X:      st_x = d[START_W-1:0];
      REG_START_Y:      st_y = d[START_W-1:0];
      default: ;
    endcase
  endtask

  task automatic take_load(logic [PIX_W-1:0] pix);
    int s, w, h, xo, yo;
    s  = fit(int'(stride), 1, STRIDE_MAX);
    w  = fit(int'(rect_w), 1, TILE_WIDTH);
    h  = fit(int'(rect_h), 1, TILE_HEIGHT);
    xo = int'(x_off);
    yo = int'(y_off);
    if (ld_col >= s) ld_col = 0;
    if (ld_row >= yo && ld_row < yo + h && ld_col >= xo && ld_col < xo + w)
      tile_mem[(ld_row - yo) * TILE_WIDTH + (ld_col - xo)] = pix;
    ld_col++;
    if (ld_col >= s) begin
      ld_col = 0;
      if (ld_row < LROW_MAX) ld_row++;
    end
  endtask

  task automatic take_emit();
    int w, h, cols, rows, c, r, px, py, sx, sy, ox, oy;
    bit quarter, fin;
    blit_pix_t e;
    w = fit(int'(rect_w), 1, TILE_WIDTH);
    h = fit(int'(rect_h), 1, TILE_HEIGHT);
    quarter = (rot == ROT_90 || rot == ROT_270);
    cols = quarter ? h : w;
    rows = quarter ? w : h;
    sx = st_x;
    sy = st_y;
    // counters left out of range by a register change restart at zero
    if (em_col >= cols) em_col = 0;
    if (em_row >= rows) em_row = 0;
    c = em_col;
    r = em_row;
    case (rot)
      ROT_90: begin
        px = r;  py = h - 1 - c;
        ox = PANEL_WIDTH - (sy + h);  oy = sx;
      end
      ROT_180: begin
        px = w - 1 - c;  py = h - 1 - r;
        ox = PANEL_WIDTH - (sx + w);  oy = PANEL_HEIGHT - (sy + h);
      end
      ROT_270: begin
        px = w - 1 - r;  py = c;
        ox = sy;  oy = PANEL_HEIGHT - (sx + w);
      end
      default: begin
        px = c;  py = r;
        ox = sx; oy = sy;
      end
    endcase
    fin = (c == cols - 1) && (r == rows - 1);
    e.pixel = tile_mem[(py * TILE_WIDTH + px) % TILE_DEPTH];
    e.dx    = clip_coord(ox + c);
    e.dy    = clip_coord(oy + r);
    e.last  = fin;
    pix_q.push_back(e);
    if (fin) begin
      em_col = 0; em_row = 0;
      ld_col = 0; ld_row = 0;
    end else if (c + 1 >= cols) begin
      em_col = 0;
      em_row = r + 1;
    end else begin
      em_col = c + 1;
    end
  endtask

  task automatic check_word();
    blit_pix_t e;
    if (pix_q.size() == 0) begin
      $error("output word with nothing expected: pixel_out %h", out_mon_i.pixel_out);
      n_bad++;
      return;
    end
    e = pix_q.pop_front();
    if (out_mon_i.pixel_out !== e.pixel) begin
      $error("pixel_out: expected %h, got %h", e.pixel, out_mon_i.pixel_out);
      n_bad++;
    end
    if (out_mon_i.dest_x !== e.dx) begin
      $error("dest_x: expected %0d, got %0d", e.dx, out_mon_i.dest_x);
      n_bad++;
    end
    if (out_mon_i.dest_y !== e.dy) begin
      $error("dest_y: expected %0d, got %0d", e.dy, out_mon_i.dest_y);
      n_bad++;
    end
    if (out_mon_i.last !== e.last) begin
      $error("last: expected %b, got %b", e.last, out_mon_i.last);
      n_bad++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot = ROT_0;
      rect_w = DIM_W'(1);
      rect_h = DIM_W'(1);
      x_off = '0;
      y_off = '0;
      stride = STRIDE_W'(1);
      st_x = '0;
      st_y = '0;
      ld_col = 0; ld_row = 0;
      em_col = 0; em_row = 0;
      pix_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_reg(reg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.operation == OP_EMIT) take_emit();
        else take_load(in_mon_i.pixel_in);
      end
      if (out_mon_i.valid && out_mon_i.ready) check_word();
      pending_o <= pix_q.size();
    end
  end

endmodule

FILE: tb/rotated_tile_blit_tb.sv
// Top of the rotated tile blitter testbench: clock, reset, register writes,
// input and output stream drivers and the verdict.
// Depends on rtb_pkg, rtb_if.sv, the block and rotated_tile_blit_checker.
module rotated_tile_blit_tb;
  import rtb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 550;
  localparam int EMIT_CAP     = 300;
  localparam int EMIT_ALL     = -1;
  localparam int EMIT_SOME    = -2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_go = 1'b0;
  int fail_cnt, pending_cnt;
  int cycles = 0;
  int src_idle = 11;
  int snk_idle = 71;
  int em_col, em_row, n_sent;
  cfg_t cur;

  rtb_in_if  in_if();
  rtb_out_if out_if();

  rotated_tile_blit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  rotated_tile_blit_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon_i   (in_if),
    .out_mon_i  (out_if),
    .fail_o     (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rotated_tile_blit_tb NOT OK");
      $finish;
    end
  end

  // output side: random back-pressure, plus one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go <= 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  function automatic int dim_clamp(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic cfg_t mk_cfg(rot_e r, int w, int h, int xo, int yo, int st,
                                  int sx, int sy);
    cfg_t m;
    m.rotation     = r;
    m.rect_width   = DIM_W'(w);
    m.rect_height  = DIM_W'(h);
    m.src_x_offset = OFFS_W'(xo);
    m.src_y_offset = OFFS_W'(yo);
    m.row_pitch    = STRIDE_W'(st);
    m.start_x      = START_W'(sx);
    m.start_y      = START_W'(sy);
    return m;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_field(cfg_t c, reg_idx_e ri);
    case (ri)
      REG_ROTATION:     return CFG_DATA_W'(c.rotation);
      REG_RECT_WIDTH:   return CFG_DATA_W'(c.rect_width);
      REG_RECT_HEIGHT:  return CFG_DATA_W'(c.rect_height);
      REG_SRC_X_OFFSET: return CFG_DATA_W'(c.src_x_offset);
      REG_SRC_Y_OFFSET: return CFG_DATA_W'(c.src_y_offset);
      REG_ROW_PITCH:    return CFG_DATA_W'(c.row_pitch);
      REG_START_X:      return CFG_DATA_W'(c.start_x);
      default:          return CFG_DATA_W'(c.start_y);
    endcase
  endfunction

  // output grid of the rotated window
  function automatic void grid_dims(cfg_t c, output int cols, output int rows);
    int w, h;
    w = dim_clamp(int'(c.rect_width), TILE_WIDTH);
    h = dim_clamp(int'(c.rect_height), TILE_HEIGHT);
    if (c.rotation == ROT_90 || c.rotation == ROT_270) begin
      cols = h; rows = w;
    end else begin
      cols = w; rows = h;
    end
  endfunction

  // emits still needed to reach the last word of the current window
  function automatic int emits_left();
    int cols, rows, c, r;
    grid_dims(cur, cols, rows);
    c = (em_col >= cols) ? 0 : em_col;
    r = (em_row >= rows) ? 0 : em_row;
    return cols * rows - (r * cols + c);
  endfunction

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic setup(cfg_t c);
    reg_idx_e ri;
    wait_idle();
    cur = c;
    ri = ri.first();
    do begin
      cfg_we   <= 1'b1;
      cfg_idx  <= ri;
      cfg_data <= reg_field(c, ri);
      @(posedge clk_i);
      ri = ri.next();
    end while (ri != ri.first());
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic op, logic [PIX_W-1:0] pix);
    int cols, rows;
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.pixel_in  <= pix;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    n_sent++;
    if (op == OP_EMIT) begin
      grid_dims(cur, cols, rows);
      if (em_col >= cols) em_col = 0;
      if (em_row >= rows) em_row = 0;
      if (em_col == cols - 1 && em_row == rows - 1) begin
        em_col = 0; em_row = 0;
      end else if (em_col + 1 >= cols) begin
        em_col = 0; em_row++;
      end else begin
        em_col++;
      end
    end
  endtask

  task automatic blit(cfg_t c, int n_load, int n_emit, bit mixed);
    int nl, ne, left;
    setup(c);
    nl = n_load;
    ne = n_emit;
    if (n_emit < 0) begin
      left = emits_left();
      if (n_emit == EMIT_SOME || left > EMIT_CAP)
        ne = $urandom_range(1, (left < 40) ? left : 40);
      else
        ne = left;
    end
    while (nl + ne > 0) begin
      if (ne == 0 || (nl > 0 && (!mixed || $urandom_range(0, nl + ne - 1) < nl))) begin
        send_word(OP_LOAD, PIX_W'($urandom));
        nl--;
      end else begin
        send_word(OP_EMIT, PIX_W'($urandom));
        ne--;
      end
    end
  endtask

  function automatic int rand_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(TILE_WIDTH, DIM_MAX);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // mostly whole windows loaded and emitted; some cut short or interleaved
  task automatic rand_blit();
    cfg_t c;
    int w, h, xo, yo, st, full, nl, ne;
    w  = rand_dim();
    h  = rand_dim();
    xo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
    yo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 2);
    st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                     : xo + dim_clamp(w, TILE_WIDTH) + $urandom_range(0, 3);
    c = mk_cfg(rot_e'($urandom_range(0, 3)), w, h, xo, yo, st,
               $urandom_range(0, 2047), $urandom_range(0, 2047));
    full = (yo + dim_clamp(h, TILE_HEIGHT)) * dim_clamp(st, STRIDE_MAX);
    nl = (full <= EMIT_CAP) ? full : $urandom_range(0, 20);
    if ($urandom_range(0, 7) == 0) nl = $urandom_range(0, nl);
    case ($urandom_range(0, 9))
      7, 8:    ne = EMIT_SOME;
      9:       ne = 0;
      default: ne = EMIT_ALL;
    endcase
    blit(c, nl, ne, $urandom_range(0, 5) == 0);
  endtask

  initial begin
    rot_e rr;
    int p, base;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_LOAD;
    in_if.pixel_in  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_ROTATION;
    cfg_data <= '0;
    em_col = 0;
    em_row = 0;
    n_sent = 0;
    cur = mk_cfg(ROT_0, 1, 1, 0, 0, 1, 0, 0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the whole tile store once so no emit ever reads an unwritten entry
    blit(mk_cfg(ROT_0, TILE_WIDTH, TILE_HEIGHT, 0, 0, TILE_WIDTH, 0, 0), TILE_DEPTH, 0, 0);
    // oversized window clamps; a few emits leave the counters mid-window
    blit(mk_cfg(ROT_90, DIM_MAX, DIM_MAX, 0, 0, TILE_WIDTH, -1024, 1023), 0, 5, 0);
    // zero sizes and stride clamp up, counters fall back to zero, last word
    blit(mk_cfg(ROT_180, 0, 0, 1023, 1023, 0, 1023, -1024), 3, EMIT_ALL, 0);
    rr = rr.first();
    do begin
      blit(mk_cfg(rr, 3, 2, 1, 1, 5, $urandom_range(0, 2047), $urandom_range(0, 2047)),
           15, EMIT_ALL, 0);
      rr = rr.next();
    end while (rr != rr.first());
    // unit stride runs the load row counter into its ceiling
    blit(mk_cfg(ROT_270, 2, 3, 0, 1, 0, 100, -100), 2100, EMIT_ALL, 0);
    // stride clamps down, window runs past the row end
    blit(mk_cfg(ROT_0, TILE_WIDTH, 1, 1000, 0, 2047, -1, 1023), STRIDE_MAX, EMIT_ALL, 0);

    for (p = 0; p < 3; p++) begin
      case (p)
        0:       begin src_idle = 11; snk_idle = 71; end
        1:       begin src_idle = 71; snk_idle = 11; end
        default: begin src_idle = 0;  snk_idle = 0;  end
      endcase
      if (p == 2) begin
        wait_idle();
        hold_go <= 1'b1;
        blit(mk_cfg(ROT_90, 8, 8, 0, 0, 8, 5, 7), 64, EMIT_ALL, 0);
      end
      base = n_sent;
      while (n_sent - base < RAND_ITEMS / 3) rand_blit();
    end

    wait_idle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("rotated_tile_blit_tb OK");
    end else begin
      $display("rotated_tile_blit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/rtb_pkg.sv
sv/rtb_if.sv
sv/rtb_ram.sv
sv/rtb_queue.sv
sv/rtb_front.sv
sv/rtb_back.sv
sv/rotated_tile_blit.sv
tb/rotated_tile_blit_checker.sv
tb/rotated_tile_blit_tb.sv
